>>> design/mtq_pkg.sv
`timescale 1ns / 1ps
package mtq_pkg;

    localparam int ID_W   = 16;
    localparam int CLS_W  = 3;
    localparam int LIM_W  = 5;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd5;

    typedef enum logic [1:0] {
        ACT_ADD        = 2'd0,
        ACT_TAKE_ANY   = 2'd1,
        ACT_TAKE_CLASS = 2'd2,
        ACT_REMOVE     = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } state_t;

    typedef struct packed {
        action_t           action;
        logic [CLS_W-1:0]  item_class;
        logic [ID_W-1:0]   item_id;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   taken_id;
        logic [CLS_W-1:0]  taken_class;
        logic [LIM_W-1:0]  items_held;
        logic [LIM_W-1:0]  slots_free;
    } rsp_t;

    typedef struct packed {
        logic              vld;
        logic [ID_W-1:0]   id;
        logic [CLS_W-1:0]  cls;
    } cell_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   id;
        logic [CLS_W-1:0]  cls;
    } sel_t;

endpackage

>>> design/mtq_cell.sv
`timescale 1ns / 1ps
module mtq_cell
    import mtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      capture,
    input  req_t      op,
    input  req_t      fill,
    input  cell_ctl_t ctl,
    input  cell_t     upper,
    output cell_t     content,
    output logic      hit
);

    logic             vld_reg;
    logic             vld_next;
    logic [ID_W-1:0]  id_reg;
    logic [ID_W-1:0]  id_next;
    logic [CLS_W-1:0] cls_reg;
    logic [CLS_W-1:0] cls_next;
    logic             hit_reg;
    logic             hit_next;

    // match against the word being accepted; held until the commit cycle
    always_comb
    begin
        hit_next = hit_reg;
        if (capture)
        begin
            unique case (op.action)
                ACT_ADD:        hit_next = 1'b0;
                ACT_TAKE_ANY:   hit_next = vld_reg;
                ACT_TAKE_CLASS: hit_next = vld_reg && (cls_reg == op.item_class);
                ACT_REMOVE:     hit_next = vld_reg && (id_reg == op.item_id);
            endcase
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        id_next  = id_reg;
        cls_next = cls_reg;
        if (ctl.load)
        begin
            vld_next = 1'b1;
            id_next  = fill.item_id;
            cls_next = fill.item_class;
        end
        else if (ctl.shift)
        begin
            vld_next = upper.vld;
            id_next  = upper.id;
            cls_next = upper.cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        cls_reg <= cls_next;
    end

    assign content = '{vld: vld_reg, id: id_reg, cls: cls_reg};
    assign hit     = hit_reg;

endmodule

>>> design/mtq_select.sv
`timescale 1ns / 1ps
module mtq_select
    import mtq_pkg::*;
#(
    parameter int MAX_ITEMS   = 16,
    parameter int NUM_CLASSES = 8
)
(
    input  logic [MAX_ITEMS-1:0] hit,
    input  cell_t                cells [MAX_ITEMS],
    output sel_t                 sel,
    output logic [MAX_ITEMS-1:0] shift
);

    localparam int NC = (NUM_CLASSES < (1 << CLS_W)) ? NUM_CLASSES : (1 << CLS_W);

    logic [NC-1:0]        class_any;
    logic [CLS_W-1:0]     low_cls;
    logic [MAX_ITEMS-1:0] cand;
    logic [MAX_ITEMS-1:0] take;

    // which classes have a matching cell
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            class_any[c] = 1'b0;
            for (int i = 0; i < MAX_ITEMS; i++)
                class_any[c] = class_any[c] | (hit[i] && (cells[i].cls == CLS_W'(c)));
        end
    end

    // lowest class wins
    always_comb
    begin
        low_cls = '0;
        for (int c = NC - 1; c >= 0; c--)
            if (class_any[c])
                low_cls = CLS_W'(c);
    end

    // oldest cell of that class; it and every younger cell advance one place
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            cand[i]  = hit[i] && (cells[i].cls == low_cls);
            take[i]  = cand[i] && !seen;
            seen     = seen | cand[i];
            shift[i] = seen;
        end
    end

    always_comb
    begin
        sel.found = |cand;
        sel.id    = '0;
        sel.cls   = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            sel.id  = sel.id  | ({ID_W{take[i]}}  & cells[i].id);
            sel.cls = sel.cls | ({CLS_W{take[i]}} & cells[i].cls);
        end
    end

endmodule

>>> design/multiclass_shared_capacity_queue.sv
`timescale 1ns / 1ps
// Shared-capacity multi-class queue of item identifiers.
// req channel (req_valid/req_ready/req_data): one word per operation:
//   add, take oldest of lowest non-empty class, take oldest of a class,
//   remove first match of an id (classes ascending, oldest first).
// rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one word per request,
//   with success flag, taken id and class, items held and slots free.
// cfg channel (cfg_valid/cfg_ready/cfg_data): capacity limit, always ready;
//   the limit in force saturates at MAX_ITEMS. Write only while idle.
// Storage is a row of cells kept packed in arrival order. A request runs
// as follows: the accepting edge latches per-cell match flags; the commit
// edge, reached once the response register is free, picks the winning cell,
// shifts the younger cells down one place and loads the response register.
// The next request is taken once the current one has committed.
// If the receiver stalls with a response pending, the next request waits in
// evaluation until the response register frees.
// Reset empties every cell, clears the count and sets the limit to 5.
module multiclass_shared_capacity_queue
    import mtq_pkg::*;
#(
    parameter int MAX_ITEMS   = 16,
    parameter int NUM_CLASSES = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req_data,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LIM_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = (CW > LIM_W) ? CW : LIM_W;

    state_t            state_reg;
    state_t            state_next;
    req_t              op_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [LIM_W-1:0]  cap_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic              capture;
    logic              commit;
    logic [WW-1:0]     lim;
    logic              add_ok;
    logic [WW-1:0]     held_w;

    cell_t                cells [MAX_ITEMS];
    cell_ctl_t            ctl   [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] hit;
    logic [MAX_ITEMS-1:0] shift;
    logic [MAX_ITEMS-1:0] vld_vec;
    logic [MAX_ITEMS-1:0] packed_vec;
    sel_t                 sel;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++)
        begin : g_cell
            cell_t upper;
            if (g == MAX_ITEMS - 1)
            begin : g_top
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = cells[g+1];
            end

            assign ctl[g].load  = commit && add_ok && (count_reg == CW'(g));
            assign ctl[g].shift = commit && shift[g];
            assign vld_vec[g]   = cells[g].vld;

            mtq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .capture (capture),
                .op      (req_data),
                .fill    (op_reg),
                .ctl     (ctl[g]),
                .upper   (upper),
                .content (cells[g]),
                .hit     (hit[g])
            );
        end
    endgenerate

    mtq_select #(
        .MAX_ITEMS   (MAX_ITEMS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_select (
        .hit   (hit),
        .cells (cells),
        .sel   (sel),
        .shift (shift)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_EVAL;
            ST_EVAL: if (!rsp_valid_reg || rsp_ready) state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_EVAL: commit    = !rsp_valid_reg || rsp_ready;
        endcase
    end

    assign capture   = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign lim    = (WW'(cap_reg) > WW'(MAX_ITEMS)) ? WW'(MAX_ITEMS) : WW'(cap_reg);
    assign add_ok = (op_reg.action == ACT_ADD)
                 && (7'(op_reg.item_class) < 7'(NUM_CLASSES))
                 && (WW'(count_reg) < lim)
                 && (WW'(count_reg) < WW'(MAX_ITEMS));

    always_comb
    begin
        count_next = count_reg;
        if (commit)
        begin
            if (add_ok)
                count_next = count_reg + CW'(1);
            else if (sel.found)
                count_next = count_reg - CW'(1);
        end
    end

    assign held_w = WW'(count_next);

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg;
        if (rsp_ready)
            rsp_valid_next   = 1'b0;
        if (commit)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.ok          = (op_reg.action == ACT_ADD) ? add_ok : sel.found;
            rsp_next.taken_id    = sel.id;
            rsp_next.taken_class = sel.cls;
            rsp_next.items_held  = LIM_W'(held_w);
            rsp_next.slots_free  = (lim > held_w) ? LIM_W'(lim - held_w) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                cap_reg   <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (capture)
            op_reg <= req_data;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // expected valid pattern: the lowest count_reg cells hold items
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
            packed_vec[i] = (CW'(i) < count_reg);
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(count_reg) <= WW'(MAX_ITEMS))
        else $error("held count above storage size");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        vld_vec == packed_vec)
        else $error("valid cells not packed to match held count");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("held count moved outside a commit");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.ok) |-> (rsp_data.taken_id == '0 && rsp_data.taken_class == '0))
        else $error("failed operation reports a taken item");

endmodule
